/* rtl/sorted_timer_queue_macros.svh */
// Assertion macros used by the timer queue port checker.
`ifndef SORTED_TIMER_QUEUE_MACROS_SVH
`define SORTED_TIMER_QUEUE_MACROS_SVH

// Plain property, clocked on clk_i and disabled while rst_ni is low.
`define STQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, clocked on clk_i and disabled while rst_ni is low.
`define STQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled while rst_ni is low.
`define STQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/stq_pkg.sv */
// Types, constants and codes of the sorted timer queue.
package stq_pkg;

  // Number of slots in the sorted list
  localparam int unsigned DEPTH = 16;
  // Timer ids are four bits wide, so sixteen of them exist
  localparam int unsigned ID_W = 4;
  localparam int unsigned ID_COUNT = 2 ** ID_W;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned IVAL_W = 32;
  // A deadline is time plus interval, one bit wider than time
  localparam int unsigned DL_W = TIME_W + 1;
  localparam int unsigned SLOT_ADDR_W = $clog2(DEPTH);
  localparam int unsigned SLOT_CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_TICK   = 2'd2
  } stq_req_e;

  typedef enum logic [2:0] {
    RS_ADDED          = 3'd0,
    RS_REMOVED        = 3'd1,
    RS_EXPIRED        = 3'd2,
    RS_NONE_EXPIRED   = 3'd3,
    RS_FULL           = 3'd4,
    RS_NOT_ACTIVE     = 3'd5,
    RS_ALREADY_ACTIVE = 3'd6
  } stq_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_WALK,
    S_ADD_PUT,
    S_REM_WALK,
    S_TICK_SCAN,
    S_TICK_SHIFT,
    S_RESP
  } stq_state_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ID_W-1:0]   timer_id;
    logic [IVAL_W-1:0] interval;
    logic [TIME_W-1:0] now_ms;
  } stq_req_t;

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    logic [2:0]      status;
    logic            last;
  } stq_rsp_t;

  // One entry of the sorted list
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] dl;
  } stq_slot_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic add_step;
    logic put_new;
    logic rem_step;
    logic scan_step;
    logic shift_step;
    logic resp_load;
  } stq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] in_kind;
    logic       in_active;
    logic       full;
    logic       used_zero;
    logic       add_stop;
    logic       p_zero;
    logic       p_last;
    logic       scan_exp;
    logic       scan_emit;
    logic       skip_shift;
    logic       out_free;
  } stq_sts_t;

endpackage

/* rtl/stq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module stq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/stq_ctrl.sv */
// Controller state machine of the sorted timer queue.
module stq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  stq_pkg::stq_sts_t sts_i,
  output stq_pkg::stq_cmd_t cmd_o
);

  stq_pkg::stq_state_e state_q, state_d;
  logic scan_stall;

  // Hold the scan while a result has nowhere to go
  assign scan_stall = sts_i.scan_emit && !sts_i.out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (sts_i.in_kind)
            stq_pkg::REQ_ADD: begin
              if (sts_i.in_active || sts_i.full) begin
                state_d = stq_pkg::S_RESP;
              end else if (sts_i.used_zero) begin
                state_d = stq_pkg::S_ADD_PUT;
              end else begin
                state_d = stq_pkg::S_ADD_WALK;
              end
            end
            stq_pkg::REQ_REMOVE: begin
              state_d = sts_i.in_active ? stq_pkg::S_REM_WALK : stq_pkg::S_RESP;
            end
            stq_pkg::REQ_TICK: state_d = stq_pkg::S_TICK_SCAN;
            default: state_d = stq_pkg::S_IDLE;
          endcase
        end
      end
      stq_pkg::S_ADD_WALK: begin
        if (sts_i.add_stop) begin
          state_d = stq_pkg::S_RESP;
        end else if (sts_i.p_zero) begin
          state_d = stq_pkg::S_ADD_PUT;
        end
      end
      stq_pkg::S_ADD_PUT: state_d = stq_pkg::S_RESP;
      stq_pkg::S_REM_WALK: begin
        if (sts_i.p_last) begin
          state_d = stq_pkg::S_RESP;
        end
      end
      stq_pkg::S_TICK_SCAN: begin
        if (!scan_stall && !sts_i.scan_exp) begin
          state_d = sts_i.skip_shift ? stq_pkg::S_IDLE : stq_pkg::S_TICK_SHIFT;
        end
      end
      stq_pkg::S_TICK_SHIFT: begin
        if (sts_i.p_last) begin
          state_d = stq_pkg::S_IDLE;
        end
      end
      stq_pkg::S_RESP: begin
        if (sts_i.out_free) begin
          state_d = stq_pkg::S_IDLE;
        end
      end
      default: state_d = stq_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      stq_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.accept  = in_valid_i;
      end
      stq_pkg::S_ADD_WALK:   cmd_o.add_step   = 1'b1;
      stq_pkg::S_ADD_PUT:    cmd_o.put_new    = 1'b1;
      stq_pkg::S_REM_WALK:   cmd_o.rem_step   = 1'b1;
      stq_pkg::S_TICK_SCAN:  cmd_o.scan_step  = !scan_stall;
      stq_pkg::S_TICK_SHIFT: cmd_o.shift_step = 1'b1;
      stq_pkg::S_RESP:       cmd_o.resp_load  = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/stq_datapath.sv */
// Datapath of the sorted timer queue: slot RAM, counters, id flags and result register.
module stq_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stq_pkg::stq_req_t in_data_i,
  input  stq_pkg::stq_cmd_t cmd_i,
  output stq_pkg::stq_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output stq_pkg::stq_rsp_t out_data_o
);

  localparam int unsigned CW = stq_pkg::SLOT_CNT_W;
  localparam int unsigned AW = stq_pkg::SLOT_ADDR_W;
  localparam int unsigned IW = stq_pkg::ID_W;

  logic [CW-1:0]                  used_q, used_d, p_q, p_d, h_q, h_d;
  logic [stq_pkg::TIME_W-1:0]     cur_q, cur_d;
  logic [stq_pkg::DL_W-1:0]       dl_q, dl_d;
  logic [stq_pkg::ID_COUNT-1:0]   active_q, active_d;
  logic                           found_q, found_d, pend_q, pend_d;
  logic [IW-1:0]                  pend_id_q, pend_id_d, id_q, id_d, resp_id_q, resp_id_d;
  stq_pkg::stq_status_e           resp_st_q, resp_st_d;
  logic                           out_valid_q, out_valid_d;
  stq_pkg::stq_rsp_t              out_q, out_d;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr, ram_raddr;
  stq_pkg::stq_slot_t             ram_wdata, rslot, new_slot;
  logic [$bits(stq_pkg::stq_slot_t)-1:0] ram_rdata;

  logic [CW-1:0] p_m1, p_p1, p_sub_h, used_m1;
  logic          in_active, full, out_free, scan_exp, add_stop;

  assign p_m1     = p_q - CW'(1);
  assign p_p1     = p_q + CW'(1);
  assign p_sub_h  = p_q - h_q;
  assign used_m1  = used_q - CW'(1);
  assign rslot    = ram_rdata;
  assign new_slot = '{id: id_q, dl: dl_q};

  assign in_active = active_q[in_data_i.timer_id];
  assign full      = (used_q >= CW'(stq_pkg::DEPTH));
  assign out_free  = !out_valid_q || out_ready_i;
  assign add_stop  = (rslot.dl <= dl_q);
  assign scan_exp  = (p_q < used_q) && (rslot.dl <= {1'b0, cur_q});

  // Report status to the controller
  always_comb begin
    sts_o            = '0;
    sts_o.in_kind    = in_data_i.req_type;
    sts_o.in_active  = in_active;
    sts_o.full       = full;
    sts_o.used_zero  = (used_q == '0);
    sts_o.add_stop   = add_stop;
    sts_o.p_zero     = (p_q == '0);
    sts_o.p_last     = (p_q == used_m1);
    sts_o.scan_exp   = scan_exp;
    sts_o.scan_emit  = scan_exp ? pend_q : 1'b1;
    sts_o.skip_shift = (p_q == '0) || (p_q == used_q);
    sts_o.out_free   = out_free;
  end

  // Carry out the command of this cycle
  always_comb begin
    used_d      = used_q;
    p_d         = p_q;
    h_d         = h_q;
    cur_d       = cur_q;
    dl_d        = dl_q;
    active_d    = active_q;
    found_d     = found_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    id_d        = id_q;
    resp_id_d   = resp_id_q;
    resp_st_d   = resp_st_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = p_q[AW-1:0];
    ram_wdata   = rslot;
    ram_raddr   = p_q[AW-1:0];

    if (cmd_i.accept) begin
      // Latch the request and prime the first slot read
      id_d      = in_data_i.timer_id;
      resp_id_d = in_data_i.timer_id;
      dl_d      = {1'b0, cur_q} + stq_pkg::DL_W'(in_data_i.interval);
      found_d   = 1'b0;
      pend_d    = 1'b0;
      p_d       = '0;
      ram_raddr = '0;
      case (in_data_i.req_type)
        stq_pkg::REQ_ADD: begin
          p_d       = used_m1;
          ram_raddr = used_m1[AW-1:0];
          if (in_active) begin
            resp_st_d = stq_pkg::RS_ALREADY_ACTIVE;
          end else if (full) begin
            resp_st_d = stq_pkg::RS_FULL;
          end else begin
            resp_st_d = stq_pkg::RS_ADDED;
          end
        end
        stq_pkg::REQ_REMOVE: begin
          resp_st_d = in_active ? stq_pkg::RS_REMOVED : stq_pkg::RS_NOT_ACTIVE;
        end
        stq_pkg::REQ_TICK: cur_d = in_data_i.now_ms;
        default: ;
      endcase
    end

    if (cmd_i.add_step) begin
      // Move a later slot up by one, or drop the new timer in behind it
      ram_we    = 1'b1;
      ram_waddr = p_p1[AW-1:0];
      if (add_stop) begin
        ram_wdata      = new_slot;
        used_d         = used_q + CW'(1);
        active_d[id_q] = 1'b1;
      end else begin
        ram_wdata = rslot;
        p_d       = p_m1;
        ram_raddr = p_m1[AW-1:0];
      end
    end

    if (cmd_i.put_new) begin
      // Place the new timer at the head
      ram_we         = 1'b1;
      ram_waddr      = '0;
      ram_wdata      = new_slot;
      used_d         = used_q + CW'(1);
      active_d[id_q] = 1'b1;
    end

    if (cmd_i.rem_step) begin
      // Skip the matching slot and close the gap behind it
      if (found_q) begin
        ram_we    = 1'b1;
        ram_waddr = p_m1[AW-1:0];
        ram_wdata = rslot;
      end else if (rslot.id == id_q) begin
        found_d = 1'b1;
      end
      p_d       = p_p1;
      ram_raddr = p_p1[AW-1:0];
      if (p_q == used_m1) begin
        used_d         = used_m1;
        active_d[id_q] = 1'b0;
      end
    end

    if (cmd_i.scan_step) begin
      // Emit expired timers one behind, so the final one can carry last
      if (scan_exp) begin
        active_d[rslot.id] = 1'b0;
        p_d                = p_p1;
        ram_raddr          = p_p1[AW-1:0];
        if (pend_q) begin
          out_d       = '{result_id: pend_id_q, status: stq_pkg::RS_EXPIRED, last: 1'b0};
          out_valid_d = 1'b1;
        end
        pend_d    = 1'b1;
        pend_id_d = rslot.id;
      end else begin
        if (pend_q) begin
          out_d = '{result_id: pend_id_q, status: stq_pkg::RS_EXPIRED, last: 1'b1};
        end else begin
          out_d = '{result_id: '0, status: stq_pkg::RS_NONE_EXPIRED, last: 1'b1};
        end
        out_valid_d = 1'b1;
        pend_d      = 1'b0;
        h_d         = p_q;
        if ((p_q == '0) || (p_q == used_q)) begin
          used_d = used_q - p_q;
        end
      end
    end

    if (cmd_i.shift_step) begin
      // Move the surviving slots down over the expired ones
      ram_we    = 1'b1;
      ram_waddr = p_sub_h[AW-1:0];
      ram_wdata = rslot;
      p_d       = p_p1;
      ram_raddr = p_p1[AW-1:0];
      if (p_q == used_m1) begin
        used_d = used_q - h_q;
      end
    end

    if (cmd_i.resp_load) begin
      // Load the single result of an add or remove request
      out_d       = '{result_id: resp_id_q, status: resp_st_q, last: 1'b1};
      out_valid_d = 1'b1;
    end
  end

  stq_ram #(
    .Width($bits(stq_pkg::stq_slot_t)),
    .Depth(stq_pkg::DEPTH)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      cur_q       <= '0;
      active_q    <= '0;
      found_q     <= 1'b0;
      pend_q      <= 1'b0;
      p_q         <= '0;
      h_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      cur_q       <= cur_d;
      active_q    <= active_d;
      found_q     <= found_d;
      pend_q      <= pend_d;
      p_q         <= p_d;
      h_q         <= h_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dl_q      <= dl_d;
    pend_id_q <= pend_id_d;
    id_q      <= id_d;
    resp_id_q <= resp_id_d;
    resp_st_q <= resp_st_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/sorted_timer_queue.sv */
// Top level of the sorted timer queue.
// Keeps up to DEPTH armed timers in one RAM ordered by deadline and works one
// request at a time: in_ready_o is high only while no request is in progress.
// Every tick, and each add or remove that is not refused, walks the list through
// the slot RAM, one slot per cycle while no stalled result holds it, on its single
// write and registered read port. An add shifts later slots up from the tail, a
// remove closes the gap behind the removed slot, and a tick scans the expired
// timers, then moves the surviving slots down when the list must be compacted.
// A stalled result register holds the scan of a tick, while add and
// remove results wait in their own state until the register frees. No clearing
// pass follows reset: the contents of slots beyond the fill count are never used.
module sorted_timer_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  stq_pkg::stq_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output stq_pkg::stq_rsp_t out_data_o
);

  stq_pkg::stq_cmd_t cmd;
  stq_pkg::stq_sts_t sts;

  stq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  stq_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

/* rtl/stq_checker.sv */
// Port-level checks of the sorted timer queue, bound to the top level.
`include "sorted_timer_queue_macros.svh"

module stq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input stq_pkg::stq_req_t in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input stq_pkg::stq_rsp_t out_data_o
);

  // A stalled result holds
  `STQ_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result changed while stalled")

  // Any real request keeps the block busy in the next cycle
  `STQ_ASSERT_NXT(a_busy_after_req, in_valid_i && in_ready_o && (in_data_i.req_type != 2'd3), !in_ready_o, "ready right after a request")

  // Only expiry results may be followed by more results of the same request
  `STQ_ASSERT_IMP(a_not_last_expired, out_valid_o && !out_data_o.last, out_data_o.status == stq_pkg::RS_EXPIRED, "non-final result is not an expiry")

  // Nothing expired reports id zero as the only result
  `STQ_ASSERT_IMP(a_none_expired, out_valid_o && (out_data_o.status == stq_pkg::RS_NONE_EXPIRED), (out_data_o.result_id == '0) && out_data_o.last, "bad none-expired result")

  // No undefined status code
  `STQ_ASSERT(a_status_code, !out_valid_o || (out_data_o.status != 3'd7), "undefined status code")

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (.*);

/* bench/timer_queue_checker.sv */
// Checker that tracks the armed timers and compares every result of the queue.
`timescale 1ns / 100ps
module timer_queue_checker
  import stq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  stq_req_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  stq_rsp_t    out_data_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  // Armed timers, kept in deadline order, earliest first
  stq_slot_t           timer_list[$];
  logic [TIME_W-1:0]   clock_ms;
  logic [ID_COUNT-1:0] armed;
  // Results still owed by the queue, oldest first
  stq_rsp_t            expected_rsp[$];
  int unsigned         fail_count;

  function automatic stq_rsp_t make_rsp(logic [ID_W-1:0] id, stq_status_e st, logic lst);
    stq_rsp_t rsp;
    rsp.result_id = id;
    rsp.status    = st;
    rsp.last      = lst;
    return rsp;
  endfunction

  // Apply one request to the timer list and queue the results it causes
  function automatic void predict_request(stq_req_t req);
    logic [DL_W-1:0] due;
    stq_slot_t       slot;
    int unsigned     pos;
    case (req.req_type)
      REQ_ADD: begin
        if (armed[req.timer_id]) begin
          expected_rsp.push_back(make_rsp(req.timer_id, RS_ALREADY_ACTIVE, 1'b1));
        end else if (timer_list.size() >= DEPTH) begin
          expected_rsp.push_back(make_rsp(req.timer_id, RS_FULL, 1'b1));
        end else begin
          // Place the new timer behind every equal or earlier deadline
          due = DL_W'(clock_ms) + DL_W'(req.interval);
          pos = 0;
          while (pos < timer_list.size() && timer_list[pos].dl <= due) pos++;
          slot.id = req.timer_id;
          slot.dl = due;
          timer_list.insert(pos, slot);
          armed[req.timer_id] = 1'b1;
          expected_rsp.push_back(make_rsp(req.timer_id, RS_ADDED, 1'b1));
        end
      end
      REQ_REMOVE: begin
        if (!armed[req.timer_id]) begin
          expected_rsp.push_back(make_rsp(req.timer_id, RS_NOT_ACTIVE, 1'b1));
        end else begin
          pos = 0;
          while (timer_list[pos].id != req.timer_id) pos++;
          timer_list.delete(pos);
          armed[req.timer_id] = 1'b0;
          expected_rsp.push_back(make_rsp(req.timer_id, RS_REMOVED, 1'b1));
        end
      end
      REQ_TICK: begin
        // Load the new time, then drop every timer that is due
        clock_ms = req.now_ms;
        pos = 0;
        while (timer_list.size() != 0 && timer_list[0].dl <= {1'b0, clock_ms}) begin
          slot = timer_list.pop_front();
          armed[slot.id] = 1'b0;
          expected_rsp.push_back(make_rsp(slot.id, RS_EXPIRED, 1'b0));
          pos++;
        end
        if (pos == 0) begin
          expected_rsp.push_back(make_rsp('0, RS_NONE_EXPIRED, 1'b1));
        end else begin
          expected_rsp[expected_rsp.size() - 1].last = 1'b1;
        end
      end
      default: begin
        // Unused request kind: no result, no change
      end
    endcase
  endfunction

  // Compare accepted results first, since they always belong to older requests
  always @(posedge clk_i or negedge rst_ni) begin
    stq_rsp_t want;
    if (!rst_ni) begin
      timer_list.delete();
      expected_rsp.delete();
      clock_ms = '0;
      armed = '0;
      fail_count = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp.size() == 0) begin
          $error("result with nothing expected: result_id %0d status %0d last %0d",
                 out_data_i.result_id, out_data_i.status, out_data_i.last);
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (out_data_i.result_id != want.result_id) begin
            $error("result_id: expected %0d, got %0d", want.result_id, out_data_i.result_id);
            fail_count++;
          end
          if (out_data_i.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_i.status);
            fail_count++;
          end
          if (out_data_i.last != want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data_i.last);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_request(in_data_i);
      pending_o <= expected_rsp.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

/* bench/sorted_timer_queue_tb.sv */
// Testbench top of the sorted timer queue: request stimulus, stalls and verdict.
`timescale 1ns / 100ps
module sorted_timer_queue_tb;
  import stq_pkg::*;

  localparam int unsigned REQ_COUNT    = 480;
  // Longest walk of the block with some margin, also covers ignored requests
  localparam int unsigned QUIET_CYCLES = 40;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  stq_req_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  stq_rsp_t    out_data;
  int unsigned pending;
  int unsigned fail_count;

  int unsigned       sent;
  int unsigned       burst_left;
  logic [TIME_W-1:0] last_now;
  int unsigned       stall_mode;
  int unsigned       mode_left;

  sorted_timer_queue i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  timer_queue_checker i_timer_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: switch between stall patterns after runs of random length
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_mode <= 0;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  function automatic logic [TIME_W-1:0] rand48();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic stq_req_t add_req(logic [ID_W-1:0] id, logic [IVAL_W-1:0] ival);
    stq_req_t req;
    req.req_type = REQ_ADD;
    req.timer_id = id;
    req.interval = ival;
    req.now_ms   = rand48();
    return req;
  endfunction

  function automatic stq_req_t rem_req(logic [ID_W-1:0] id);
    stq_req_t req;
    req.req_type = REQ_REMOVE;
    req.timer_id = id;
    req.interval = $urandom;
    req.now_ms   = rand48();
    return req;
  endfunction

  function automatic stq_req_t tick_req(logic [TIME_W-1:0] now);
    stq_req_t req;
    req.req_type = REQ_TICK;
    req.timer_id = ID_W'($urandom_range(0, ID_COUNT - 1));
    req.interval = $urandom;
    req.now_ms   = now;
    return req;
  endfunction

  function automatic stq_req_t unused_req();
    stq_req_t req;
    req.req_type = REQ_UNUSED;
    req.timer_id = ID_W'($urandom_range(0, ID_COUNT - 1));
    req.interval = $urandom;
    req.now_ms   = rand48();
    return req;
  endfunction

  function automatic logic [TIME_W-1:0] advance_now(int unsigned step);
    last_now = last_now + TIME_W'(step);
    return last_now;
  endfunction

  // Mostly small steps forward so that timers expire in batches
  function automatic logic [TIME_W-1:0] next_now();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return advance_now($urandom_range(0, 40));
    if (pick < 70) return last_now;
    if (pick < 80) last_now = rand48();
    else if (pick < 90) last_now = last_now - TIME_W'($urandom_range(1, 40));
    else if (pick < 95) last_now = '0;
    else last_now = '1;
    return last_now;
  endfunction

  function automatic logic [IVAL_W-1:0] random_interval();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return IVAL_W'($urandom_range(0, 60));
    if (pick < 70) return '0;
    if (pick < 85) return $urandom;
    return '1 - IVAL_W'($urandom_range(0, 3));
  endfunction

  function automatic stq_req_t random_req();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return add_req(ID_W'($urandom_range(0, ID_COUNT - 1)), random_interval());
    if (pick < 60) return rem_req(ID_W'($urandom_range(0, ID_COUNT - 1)));
    if (pick < 95) return tick_req(next_now());
    return unused_req();
  endfunction

  // Hand one request over; idle for a random gap at the start of each burst
  task automatic issue(input stq_req_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Hold off until every owed result has come and the block has settled
  task automatic wait_quiet();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Arm all ids in random order, then let them expire over a few ticks
  task automatic fill_episode();
    logic [ID_W-1:0] order[ID_COUNT];
    logic [ID_W-1:0] swap;
    int unsigned     j;
    foreach (order[i]) order[i] = ID_W'(i);
    for (int i = ID_COUNT - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    foreach (order[i]) issue(add_req(order[i], IVAL_W'($urandom_range(0, 60))));
    if ($urandom_range(0, 1) == 0) issue(rem_req(ID_W'($urandom_range(0, ID_COUNT - 1))));
    repeat ($urandom_range(1, 4)) issue(tick_req(advance_now($urandom_range(0, 40))));
    if ($urandom_range(0, 1) == 0) issue(tick_req(advance_now(60)));
  endtask

  initial begin
    bit paused;
    sent = 0;
    burst_left = 0;
    last_now = '0;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty tick, bad remove, duplicate add, equal deadlines,
    // widest deadlines, ignored request kind and time at both ends
    issue(tick_req('0));
    issue(rem_req(ID_W'(5)));
    issue(add_req(ID_W'(0), '0));
    issue(add_req(ID_W'(0), IVAL_W'(5)));
    issue(add_req(ID_W'(15), '1));
    issue(add_req(ID_W'(7), '0));
    issue(add_req(ID_W'(3), IVAL_W'(10)));
    issue(unused_req());
    issue(rem_req(ID_W'(3)));
    issue(tick_req('0));
    issue(tick_req('1));
    issue(add_req(ID_W'(1), '1));
    issue(add_req(ID_W'(2), '1 - IVAL_W'(1)));
    issue(tick_req('1));
    issue(rem_req(ID_W'(1)));
    issue(rem_req(ID_W'(2)));
    issue(tick_req('0));
    wait_quiet();

    // Random: fill episodes and mixed requests, one full drain half way
    while (sent < REQ_COUNT) begin
      if (!paused && sent >= REQ_COUNT / 2) begin
        wait_quiet();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) < 3) begin
        fill_episode();
      end else begin
        repeat ($urandom_range(5, 15)) issue(random_req());
      end
    end
    wait_quiet();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #8ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/stq_pkg.sv
rtl/stq_ram.sv
rtl/stq_ctrl.sv
rtl/stq_datapath.sv
rtl/sorted_timer_queue.sv
rtl/stq_checker.sv
bench/timer_queue_checker.sv
bench/sorted_timer_queue_tb.sv
